/* hw/rtl/rdp_pkg.sv */
// Repetition distance predictor: shared constants.
// No dependencies; used by rdp_hist_cell and repetition_distance_predictor.
`timescale 1ns / 1ps
`default_nettype none

package rdp_pkg;

    localparam int unsigned SYM_W       = 8;      // symbol width
    localparam int unsigned OUT_DIST_W  = 3;      // reported distance width
    localparam logic [SYM_W-1:0] BLANK_RESET = 8'd95;  // '_'

endpackage : rdp_pkg

`default_nettype wire

/* hw/rtl/repetition_distance_predictor.sv */
// Repetition distance predictor top level: history cell chain, prediction
// ring, blank register and output register. Depends on rdp_pkg, rdp_hist_cell.
//
//  Channel   Dir  Handshake                  Payload
//  -------   ---  -------------------------  ------------------------------
//  input     in   i_valid / o_stall          i_symbol
//  result    out  o_valid / i_stall          o_seen,
//                                            o_recent_distance, o_predicted_hit
//  config    in   i_cfg_valid / o_cfg_ready  i_cfg_data (blank symbol)
//
// One request per cycle while o_stall is low; each result appears in the cycle
// after its request is taken, held in the output register. The history
// compare is combinational and the ring updates when the request is taken.
// Input stalls only while a result waits in the output register and the
// sink stalls. Config ready is always high.
// Synchronous active-low reset: history empty, ring all '_', pointer zero.
`timescale 1ns / 1ps
`default_nettype none

module repetition_distance_predictor #(
    parameter int unsigned HISTORY_DEPTH = 4,
    parameter int unsigned PREDICT_DEPTH = 4
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // symbol requests
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [rdp_pkg::SYM_W-1:0]     i_symbol,
    // results
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic                               o_seen,
    output logic [rdp_pkg::OUT_DIST_W-1:0]     o_recent_distance,
    output logic                               o_predicted_hit,
    // blank symbol write
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [rdp_pkg::SYM_W-1:0]     i_cfg_data
);

    localparam int unsigned DIST_W = $clog2(HISTORY_DEPTH + 1);
    localparam int unsigned PTR_W  = (PREDICT_DEPTH > 1) ? $clog2(PREDICT_DEPTH) : 1;

    // ---------------------------------------------------------------- handshake
    logic w_accept;

    assign o_stall     = o_valid && i_stall;
    assign w_accept    = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    // ---------------------------------------------------------------- blank reg
    logic [rdp_pkg::SYM_W-1:0] r_blank;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blank <= rdp_pkg::BLANK_RESET;
        end else if (i_cfg_valid) begin
            r_blank <= i_cfg_data;
        end
    end

    // ---------------------------------------------------------------- pointer
    logic [PTR_W-1:0] r_ptr;
    logic [PTR_W-1:0] n_ptr;

    assign n_ptr = (r_ptr == PTR_W'(PREDICT_DEPTH - 1)) ? '0 : (r_ptr + 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
        end else if (w_accept) begin
            r_ptr <= n_ptr;
        end
    end

    // ---------------------------------------------------------------- history
    // Cell 0 holds the latest symbol. The first-match flag, its distance and
    // its ring slot ripple from newest to oldest, so the newest match wins.
    logic [rdp_pkg::SYM_W-1:0] w_sym   [HISTORY_DEPTH+1];
    logic                      w_vld   [HISTORY_DEPTH+1];
    logic                      w_found [HISTORY_DEPTH+1];
    logic [DIST_W-1:0]         w_dist  [HISTORY_DEPTH+1];
    logic [PTR_W-1:0]          w_slot  [HISTORY_DEPTH+1];

    assign w_sym[0]   = i_symbol;
    assign w_vld[0]   = 1'b1;
    assign w_found[0] = 1'b0;
    assign w_dist[0]  = '0;
    assign w_slot[0]  = '0;

    for (genvar g = 0; g < HISTORY_DEPTH; g++) begin : g_cell
        rdp_hist_cell #(
            .CELL_IDX   (g),
            .DIST_W     (DIST_W),
            .PTR_W      (PTR_W),
            .PRED_DEPTH (PREDICT_DEPTH)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_shift      (w_accept),
            .i_sym_prev   (w_sym[g]),
            .i_valid_prev (w_vld[g]),
            .o_sym        (w_sym[g+1]),
            .o_valid      (w_vld[g+1]),
            .i_symbol     (i_symbol),
            .i_ptr_next   (n_ptr),
            .i_found      (w_found[g]),
            .i_dist       (w_dist[g]),
            .i_slot       (w_slot[g]),
            .o_found      (w_found[g+1]),
            .o_dist       (w_dist[g+1]),
            .o_slot       (w_slot[g+1])
        );
    end

    // ---------------------------------------------------------------- ring
    // Slot under the pointer is blanked, then the predicted slot is written;
    // the write wins when both land on the same slot.
    logic [rdp_pkg::SYM_W-1:0] r_ring [PREDICT_DEPTH];
    logic                      w_hit;

    assign w_hit = (r_ring[r_ptr] == i_symbol);

    for (genvar s = 0; s < PREDICT_DEPTH; s++) begin : g_slot
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ring[s] <= rdp_pkg::BLANK_RESET;
            end else if (w_accept) begin
                if (w_found[HISTORY_DEPTH] && (w_slot[HISTORY_DEPTH] == PTR_W'(s))) begin
                    r_ring[s] <= i_symbol;
                end else if (r_ptr == PTR_W'(s)) begin
                    r_ring[s] <= r_blank;
                end
            end
        end
    end

    // ---------------------------------------------------------------- output
    logic                              r_out_valid;
    logic                              r_heard;
    logic [rdp_pkg::OUT_DIST_W-1:0]    r_dist;
    logic                              r_phit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_heard <= w_found[HISTORY_DEPTH];
            r_dist  <= rdp_pkg::OUT_DIST_W'(w_dist[HISTORY_DEPTH]);  // low bits only
            r_phit  <= w_hit;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_seen            = r_heard;
    assign o_recent_distance = r_dist;
    assign o_predicted_hit   = r_phit;

endmodule : repetition_distance_predictor

`default_nettype wire

/* hw/rtl/rdp_hist_cell.sv */
// One history cell: holds a symbol and its valid bit, compares with the
// incoming symbol and passes the first-match result down the chain.
// Depends on rdp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rdp_hist_cell #(
    parameter int unsigned CELL_IDX   = 0,
    parameter int unsigned DIST_W     = 3,
    parameter int unsigned PTR_W      = 2,
    parameter int unsigned PRED_DEPTH = 4
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_shift,
    input  wire logic [rdp_pkg::SYM_W-1:0] i_sym_prev,
    input  wire logic                      i_valid_prev,
    output logic      [rdp_pkg::SYM_W-1:0] o_sym,
    output logic                           o_valid,
    input  wire logic [rdp_pkg::SYM_W-1:0] i_symbol,
    input  wire logic [PTR_W-1:0]          i_ptr_next,
    input  wire logic                      i_found,
    input  wire logic [DIST_W-1:0]         i_dist,
    input  wire logic [PTR_W-1:0]          i_slot,
    output logic                           o_found,
    output logic      [DIST_W-1:0]         o_dist,
    output logic      [PTR_W-1:0]          o_slot
);

    // ring offset of this cell, fixed at elaboration
    localparam int unsigned OFS = CELL_IDX % PRED_DEPTH;

    logic [rdp_pkg::SYM_W-1:0] r_sym;
    logic                      r_valid;
    logic                      w_match;
    logic                      w_first;
    logic [PTR_W:0]            w_sum;
    logic [PTR_W:0]            w_wrap;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_sym <= i_sym_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_valid_prev;
        end
    end

    assign w_match = r_valid && (r_sym == i_symbol);
    assign w_first = w_match && !i_found;

    // both terms below PRED_DEPTH, so one conditional subtract wraps
    assign w_sum  = {1'b0, i_ptr_next} + (PTR_W+1)'(OFS);
    assign w_wrap = (w_sum >= (PTR_W+1)'(PRED_DEPTH)) ?
                    (w_sum - (PTR_W+1)'(PRED_DEPTH)) : w_sum;

    assign o_found = i_found || w_match;
    assign o_dist  = w_first ? DIST_W'(CELL_IDX + 1) : i_dist;
    assign o_slot  = w_first ? w_wrap[PTR_W-1:0] : i_slot;
    assign o_sym   = r_sym;
    assign o_valid = r_valid;

endmodule : rdp_hist_cell

`default_nettype wire
